>>> hw/rtl/tcw_pkg.sv
// Package with the constants, widths and codes of the text console writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AddrW = $clog2(CELLS);
  localparam int CntW  = $clog2(CELLS + 1);
  localparam int TabW  = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  localparam int ModeW = 4;
  localparam int CharW = 8;
  localparam int ColorW = 4;
  localparam int IdxW  = 11;
  localparam int RowW  = 5;
  localparam int ColW  = 7;
  localparam int AttrW = 8;
  localparam int CellW = 16;

  localparam logic [CharW-1:0]  BLANK_CHAR = 8'h20;
  localparam logic [CharW-1:0]  NL_CHAR    = 8'h0A;
  localparam logic [CharW-1:0]  TAB_CHAR   = 8'h09;
  localparam logic [ColorW-1:0] RESET_FG   = 4'h7;
  localparam logic [ColorW-1:0] RESET_BG   = 4'h0;

  typedef enum logic [ModeW-1:0] {
    MODE_CHAR     = 4'd0,
    MODE_TEMP_FB  = 4'd1,
    MODE_SET_FB   = 4'd2,
    MODE_TEMP_FG  = 4'd3,
    MODE_TEMP_BG  = 4'd4,
    MODE_SET_FG   = 4'd5,
    MODE_SET_BG   = 4'd6,
    MODE_REST_FG  = 4'd7,
    MODE_REST_BG  = 4'd8,
    MODE_INIT     = 4'd9,
    MODE_READ     = 4'd10
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SCROLL = 5'b00100,
    ST_CLEAR  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

endpackage

>>> hw/rtl/text_console_writer_top.sv
// Text console writer: screen memory, cursor, colours and the item sequencer.
//
//  Channel | Direction | Handshake                 | Payload
//  in      | input     | in_valid_i / in_ready_o   | mode, char_code, fg/bg_value, cell_index
//  out     | output    | out_valid_o / out_ready_i | cursor_row/col, attribute, cell_entry
//
// A plain character, newline or colour item is done in ST_EXEC; a cell read takes its
// data in ST_RESULT. A tab writes TAB_SPACES blanks, one per pass through ST_EXEC. A scroll
// runs a copy sweep through the single-port-read screen memory; an init clears it all.
// After reset the block clears the screen memory with in_ready_o low.
// One result register holds a finished result; the next item is accepted while it
// waits and finishes into it once it is taken.
module text_console_writer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tcw_pkg::ModeW-1:0]  mode_i,
  input  logic [tcw_pkg::CharW-1:0]  char_code_i,
  input  logic [tcw_pkg::ColorW-1:0] fg_value_i,
  input  logic [tcw_pkg::ColorW-1:0] bg_value_i,
  input  logic [tcw_pkg::IdxW-1:0]   cell_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tcw_pkg::RowW-1:0]   cursor_row_o,
  output logic [tcw_pkg::ColW-1:0]   cursor_col_o,
  output logic [tcw_pkg::AttrW-1:0]  attribute_o,
  output logic [tcw_pkg::CellW-1:0]  cell_entry_o
);

  tcw_pkg::state_e state_q, state_d;
  tcw_pkg::mode_e  mode_q, mode_d;
  logic [tcw_pkg::CharW-1:0]  char_q, char_d;
  logic [tcw_pkg::ColorW-1:0] fg_q, fg_d, bg_q, bg_d;
  logic [tcw_pkg::IdxW-1:0]   index_q, index_d;

  logic [tcw_pkg::RowW-1:0]   row_q, row_d;
  logic [tcw_pkg::ColW-1:0]   col_q, col_d;
  logic [tcw_pkg::AttrW-1:0]  attr_q, attr_d;
  logic [tcw_pkg::ColorW-1:0] saved_fg_q, saved_fg_d, saved_bg_q, saved_bg_d;
  logic [tcw_pkg::TabW-1:0]   glyph_left_q, glyph_left_d;
  logic [tcw_pkg::CntW-1:0]   ptr_q, ptr_d;
  logic                       clr_reply_q, clr_reply_d;

  logic                       out_valid_q, out_valid_d;
  logic [tcw_pkg::RowW-1:0]   out_row_q, out_row_d;
  logic [tcw_pkg::ColW-1:0]   out_col_q, out_col_d;
  logic [tcw_pkg::AttrW-1:0]  out_attr_q, out_attr_d;
  logic [tcw_pkg::CellW-1:0]  out_cell_q, out_cell_d;

  logic [tcw_pkg::CellW-1:0]  cells_q [tcw_pkg::CELLS];
  logic [tcw_pkg::CellW-1:0]  rdata_q;
  logic                       mem_we, mem_re;
  logic [tcw_pkg::AddrW-1:0]  mem_waddr, mem_raddr;
  logic [tcw_pkg::CellW-1:0]  mem_wdata;

  logic                       in_fire, finish, out_free, read_hit, wrap;
  logic [tcw_pkg::CharW-1:0]  glyph;
  logic [tcw_pkg::CellW-1:0]  blank_cell;

  assign in_ready_o = (state_q == tcw_pkg::ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign blank_cell = {attr_q, tcw_pkg::BLANK_CHAR};
  assign read_hit   = (int'(index_q) < tcw_pkg::CELLS);
  assign glyph      = (char_q == tcw_pkg::TAB_CHAR) ? tcw_pkg::BLANK_CHAR : char_q;
  assign wrap       = (char_q == tcw_pkg::NL_CHAR) ||
                      (col_q == tcw_pkg::ColW'(tcw_pkg::COLUMNS - 1));

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    char_d       = char_q;
    fg_d         = fg_q;
    bg_d         = bg_q;
    index_d      = index_q;
    row_d        = row_q;
    col_d        = col_q;
    attr_d       = attr_q;
    saved_fg_d   = saved_fg_q;
    saved_bg_d   = saved_bg_q;
    glyph_left_d = glyph_left_q;
    ptr_d        = ptr_q;
    clr_reply_d  = clr_reply_q;
    finish       = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_raddr    = '0;
    mem_wdata    = blank_cell;

    case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          mode_d       = tcw_pkg::mode_e'(mode_i);
          char_d       = char_code_i;
          fg_d         = fg_value_i;
          bg_d         = bg_value_i;
          index_d      = cell_index_i;
          glyph_left_d = (mode_i == tcw_pkg::MODE_CHAR &&
                          char_code_i == tcw_pkg::TAB_CHAR) ?
                         tcw_pkg::TabW'(tcw_pkg::TAB_SPACES - 1) : '0;
          state_d      = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        case (mode_q)
          tcw_pkg::MODE_CHAR: begin
            if (char_q != tcw_pkg::NL_CHAR) begin
              mem_we    = 1'b1;
              mem_waddr = tcw_pkg::AddrW'(int'(row_q) * tcw_pkg::COLUMNS + int'(col_q));
              mem_wdata = {attr_q, glyph};
            end
            if (wrap) begin
              col_d = '0;
              if (row_q == tcw_pkg::RowW'(tcw_pkg::ROWS - 1)) begin
                ptr_d   = '0;
                state_d = tcw_pkg::ST_SCROLL;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else begin
              col_d = col_q + 1'b1;
            end
            if (!(wrap && row_q == tcw_pkg::RowW'(tcw_pkg::ROWS - 1))) begin
              if (glyph_left_q != '0) begin
                glyph_left_d = glyph_left_q - 1'b1;
              end else begin
                finish = 1'b1;
              end
            end
          end
          tcw_pkg::MODE_TEMP_FB: begin
            attr_d = {bg_q, fg_q};
            finish = 1'b1;
          end
          tcw_pkg::MODE_SET_FB: begin
            attr_d     = {bg_q, fg_q};
            saved_fg_d = fg_q;
            saved_bg_d = bg_q;
            finish     = 1'b1;
          end
          tcw_pkg::MODE_TEMP_FG: begin
            attr_d = {attr_q[7:4], fg_q};
            finish = 1'b1;
          end
          tcw_pkg::MODE_TEMP_BG: begin
            attr_d = {bg_q, attr_q[3:0]};
            finish = 1'b1;
          end
          tcw_pkg::MODE_SET_FG: begin
            attr_d     = {attr_q[7:4], fg_q};
            saved_fg_d = fg_q;
            finish     = 1'b1;
          end
          tcw_pkg::MODE_SET_BG: begin
            attr_d     = {bg_q, attr_q[3:0]};
            saved_bg_d = bg_q;
            finish     = 1'b1;
          end
          tcw_pkg::MODE_REST_FG: begin
            attr_d = {attr_q[7:4], saved_fg_q};
            finish = 1'b1;
          end
          tcw_pkg::MODE_REST_BG: begin
            attr_d = {saved_bg_q, attr_q[3:0]};
            finish = 1'b1;
          end
          tcw_pkg::MODE_INIT: begin
            row_d       = '0;
            col_d       = '0;
            saved_fg_d  = tcw_pkg::RESET_FG;
            saved_bg_d  = tcw_pkg::RESET_BG;
            attr_d      = {tcw_pkg::RESET_BG, tcw_pkg::RESET_FG};
            ptr_d       = '0;
            clr_reply_d = 1'b1;
            state_d     = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::MODE_READ: begin
            mem_re    = read_hit;
            mem_raddr = tcw_pkg::AddrW'(index_q);
            state_d   = tcw_pkg::ST_RESULT;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        // The read of the row below lands in rdata_q and is written back in the next cycle.
        if (int'(ptr_q) + tcw_pkg::COLUMNS < tcw_pkg::CELLS) begin
          mem_re    = 1'b1;
          mem_raddr = tcw_pkg::AddrW'(int'(ptr_q) + tcw_pkg::COLUMNS);
        end
        if (ptr_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = tcw_pkg::AddrW'(int'(ptr_q) - 1);
          mem_wdata = (int'(ptr_q) - 1 < tcw_pkg::CELLS - tcw_pkg::COLUMNS) ?
                      rdata_q : blank_cell;
        end
        if (ptr_q == tcw_pkg::CntW'(tcw_pkg::CELLS)) begin
          if (glyph_left_q != '0) begin
            glyph_left_d = glyph_left_q - 1'b1;
            state_d      = tcw_pkg::ST_EXEC;
          end else begin
            finish = 1'b1;
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = tcw_pkg::AddrW'(ptr_q);
        mem_wdata = blank_cell;
        if (ptr_q == tcw_pkg::CntW'(tcw_pkg::CELLS - 1)) begin
          clr_reply_d = 1'b0;
          if (clr_reply_q) begin
            finish = 1'b1;
          end else begin
            state_d = tcw_pkg::ST_IDLE;
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      tcw_pkg::ST_RESULT: begin
        finish = 1'b1;
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d = out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESULT;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_attr_d  = out_attr_q;
    out_cell_d  = out_cell_q;
    if (finish && out_free) begin
      out_valid_d = 1'b1;
      out_row_d   = row_d;
      out_col_d   = col_d;
      out_attr_d  = attr_d;
      out_cell_d  = (mode_q == tcw_pkg::MODE_READ && read_hit) ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tcw_pkg::ST_CLEAR;
      row_q        <= '0;
      col_q        <= '0;
      attr_q       <= {tcw_pkg::RESET_BG, tcw_pkg::RESET_FG};
      saved_fg_q   <= tcw_pkg::RESET_FG;
      saved_bg_q   <= tcw_pkg::RESET_BG;
      glyph_left_q <= '0;
      ptr_q        <= '0;
      clr_reply_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      attr_q       <= attr_d;
      saved_fg_q   <= saved_fg_d;
      saved_bg_q   <= saved_bg_d;
      glyph_left_q <= glyph_left_d;
      ptr_q        <= ptr_d;
      clr_reply_q  <= clr_reply_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    char_q     <= char_d;
    fg_q       <= fg_d;
    bg_q       <= bg_d;
    index_q    <= index_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_attr_q <= out_attr_d;
    out_cell_q <= out_cell_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= cells_q[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign attribute_o  = out_attr_q;
  assign cell_entry_o = out_cell_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(row_q) < tcw_pkg::ROWS) && (int'(col_q) < tcw_pkg::COLUMNS))
    else $error("Cursor left the screen.");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q != tcw_pkg::ST_IDLE))
    else $error("A result appeared without an item in progress.");

  a_tab_only_for_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (glyph_left_q != '0) |-> (mode_q == tcw_pkg::MODE_CHAR))
    else $error("Pending tab glyphs outside a character transfer.");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcw_pkg::ST_SCROLL || state_q == tcw_pkg::ST_CLEAR) |->
    (int'(ptr_q) <= tcw_pkg::CELLS))
    else $error("Sweep pointer ran past the screen memory.");

endmodule
